// File: design/lppd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
`default_nettype none

package lppd_pkg;

    localparam logic [7:0] MARK_SHORT_A = 8'hC1;
    localparam logic [7:0] MARK_LONG_A  = 8'hC2;
    localparam logic [7:0] MARK_SHORT_B = 8'hC3;
    localparam logic [7:0] MARK_LONG_B  = 8'hC4;

    localparam logic [15:0] HDR_SHORT_LEN   = 16'd3;
    localparam logic [15:0] HDR_LONG_LEN    = 16'd4;
    localparam logic [15:0] MAX_LEN_DEFAULT = 16'd8192;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LENHI = 3'd1,
        PH_LENLO = 3'd2,
        PH_HEAD  = 3'd3,
        PH_BODY  = 3'd4,
        PH_ERROR = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HDR = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_start;
        logic        frame_end;
        logic [7:0]  marker_code;
        logic [15:0] frame_length;
        logic [7:0]  head_code;
        logic        head_code_valid;
        status_t     status;
    } lppd_result_t;

endpackage

`default_nettype wire

// File: design/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer.
`default_nettype none

// The deframer takes one received byte per item on the slave stream and gives
// one result item per byte on the master stream, registered through a
// single output register; with the master side ready it sustains one byte
// every clock cycle, and s_tready drops only while a finished result waits
// to be taken. A packet starts with marker 0xC1/0xC3 (one length byte, header
// of 3) or 0xC2/0xC4 (two length bytes, big-endian, header of 4), then the
// head code byte, then the body up to the declared total length. Each result
// echoes the byte with start (tuser) and end (tlast) marks, the marker, the
// declared length and the head code. An unknown marker reports bad header; a
// declared length below the header size or above max_frame_length reports bad
// length. Either error sticks until reset and later bytes pass through with
// all packet fields zero. Write max_frame_length (reset 8192) only while idle.
module length_prefixed_packet_deframer
    import lppd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,   // max_frame_length
    // received bytes
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,     // [7:0] rx_byte
    // framed results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,     // [7:0] out_byte, [15:8] marker_code,
                                           // [31:16] frame_length, [39:32] head_code
    output logic              m_tlast,     // frame_end
    output logic [3:0]        m_tuser      // [0] frame_start, [1] head_code_valid,
                                           // [3:2] status
);

    logic [15:0]  max_len_reg;
    logic         accept;
    logic         can_load;
    lppd_result_t core_result;
    lppd_result_t held_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_DEFAULT;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // Advance the framing state on every accepted byte.
    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    lppd_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .rx_byte          (s_tdata),
        .max_frame_length (max_len_reg),
        .result           (core_result)
    );

    lppd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (core_result),
        .take       (m_tready),
        .can_load   (can_load),
        .valid      (m_tvalid),
        .result_out (held_result)
    );

    // Pack the held result onto the master stream.
    assign m_tdata = {held_result.head_code, held_result.frame_length,
                      held_result.marker_code, held_result.out_byte};
    assign m_tlast = held_result.frame_end;
    assign m_tuser = {held_result.status, held_result.head_code_valid,
                      held_result.frame_start};

endmodule

`default_nettype wire

// File: design/lppd_core.sv
// Per-byte framing state machine: tracks packet phase and builds one result per byte.
`default_nettype none

module lppd_core
    import lppd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   rx_byte,
    input  wire logic [15:0]  max_frame_length,
    output lppd_result_t      result
);

    phase_t      phase_reg,  phase_next;
    logic [15:0] pos_reg,    pos_next;
    logic [15:0] len_reg,    len_next;
    logic [7:0]  marker_reg, marker_next;
    logic [7:0]  head_reg,   head_next;
    status_t     status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            len_reg    <= '0;
            marker_reg <= '0;
            head_reg   <= '0;
            status_reg <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            marker_reg <= marker_next;
            head_reg   <= head_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        logic [15:0] min_len;
        logic [15:0] pos_inc;
        logic [7:0]  head_now;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        marker_next = marker_reg;
        head_next   = head_reg;
        status_next = status_reg;
        pos_inc     = pos_reg + 16'd1;
        min_len     = ((marker_reg == MARK_LONG_A) || (marker_reg == MARK_LONG_B))
                      ? HDR_LONG_LEN : HDR_SHORT_LEN;
        head_now    = (phase_reg == PH_HEAD) ? rx_byte : head_reg;

        result                 = '0;
        result.out_byte        = rx_byte;

        unique case (phase_reg)
            PH_LENHI:
            begin
                len_next           = {rx_byte, 8'h00};
                pos_next           = 16'd2;
                phase_next         = PH_LENLO;
                result.marker_code = marker_reg;
            end
            PH_LENLO:
            begin
                len_next            = {len_reg[15:8], rx_byte};
                pos_next            = pos_inc;
                result.marker_code  = marker_reg;
                result.frame_length = len_next;
                if ((len_next < min_len) || (len_next > max_frame_length))
                begin
                    status_next = ST_BAD_LEN;
                    phase_next  = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_HEAD;
                end
            end
            PH_HEAD, PH_BODY:
            begin
                head_next              = head_now;
                pos_next               = pos_inc;
                result.head_code_valid = 1'b1;
                result.marker_code     = marker_reg;
                result.frame_length    = len_reg;
                result.head_code       = head_now;
                if (pos_inc >= len_reg)
                begin
                    result.frame_end = 1'b1;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_ERROR:
            begin
                // hold the latched error
            end
            default:
            begin
                if ((rx_byte == MARK_SHORT_A) || (rx_byte == MARK_SHORT_B))
                begin
                    marker_next        = rx_byte;
                    head_next          = '0;
                    len_next           = '0;
                    pos_next           = 16'd1;
                    phase_next         = PH_LENLO;
                    result.frame_start = 1'b1;
                    result.marker_code = rx_byte;
                end
                else if ((rx_byte == MARK_LONG_A) || (rx_byte == MARK_LONG_B))
                begin
                    marker_next        = rx_byte;
                    head_next          = '0;
                    len_next           = '0;
                    pos_next           = 16'd1;
                    phase_next         = PH_LENHI;
                    result.frame_start = 1'b1;
                    result.marker_code = rx_byte;
                end
                else
                begin
                    status_next = ST_BAD_HDR;
                    phase_next  = PH_ERROR;
                end
            end
        endcase

        result.status = status_next;
    end

endmodule

`default_nettype wire

// File: design/lppd_out_stage.sv
// Output holding register that decouples the result stream from the input stream.
`default_nettype none

module lppd_out_stage
    import lppd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire lppd_result_t  result_in,
    input  wire logic          take,
    output logic               can_load,
    output logic               valid,
    output lppd_result_t       result_out
);

    logic         valid_reg;
    lppd_result_t data_reg;

    // Room for a new item when empty or when the held one leaves this cycle.
    assign can_load   = !valid_reg || take;
    assign valid      = valid_reg;
    assign result_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

// File: test/deframer_result_checker.sv
// Checker for the packet deframer: predicts every result item and compares it.
module deframer_result_checker
    import lppd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic [3:0]  m_tuser,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow state of the deframer
    phase_t       ph;
    status_t      sts;
    logic [15:0]  pos;
    logic [15:0]  decl_len;
    logic [15:0]  max_len;
    logic [7:0]   cur_mark;
    logic [7:0]   cur_head;

    lppd_result_t predicted_results [$];
    int           result_index;

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("[%0t] result %0d: %s", $time, result_index, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Advance the shadow state by one byte and return the result it causes.
    function automatic lppd_result_t deframe_byte(input logic [7:0] b);
        lppd_result_t r;
        logic [15:0]  min_len;
        r = '0;
        r.out_byte = b;
        case (ph)
            PH_LENHI:
            begin
                decl_len = {b, 8'h00};
                pos = 16'd2;
                ph = PH_LENLO;
                r.marker_code = cur_mark;
            end
            PH_LENLO:
            begin
                decl_len = decl_len | {8'h00, b};
                pos = pos + 16'd1;
                min_len = (cur_mark == MARK_LONG_A || cur_mark == MARK_LONG_B) ?
                          HDR_LONG_LEN : HDR_SHORT_LEN;
                r.marker_code = cur_mark;
                r.frame_length = decl_len;
                if (decl_len < min_len || decl_len > max_len)
                begin
                    sts = ST_BAD_LEN;
                    ph = PH_ERROR;
                end
                else
                    ph = PH_HEAD;
            end
            PH_HEAD, PH_BODY:
            begin
                if (ph == PH_HEAD)
                    cur_head = b;
                pos = pos + 16'd1;
                r.head_code_valid = 1'b1;
                r.marker_code = cur_mark;
                r.frame_length = decl_len;
                r.head_code = cur_head;
                if (pos >= decl_len)
                begin
                    r.frame_end = 1'b1;
                    ph = PH_IDLE;
                end
                else
                    ph = PH_BODY;
            end
            PH_ERROR:
            begin
            end
            default:
            begin
                if (b == MARK_SHORT_A || b == MARK_SHORT_B ||
                    b == MARK_LONG_A || b == MARK_LONG_B)
                begin
                    cur_mark = b;
                    cur_head = 8'h00;
                    decl_len = 16'h0000;
                    pos = 16'd1;
                    ph = (b == MARK_SHORT_A || b == MARK_SHORT_B) ? PH_LENLO : PH_LENHI;
                    r.frame_start = 1'b1;
                    r.marker_code = b;
                end
                else
                begin
                    sts = ST_BAD_HDR;
                    ph = PH_ERROR;
                end
            end
        endcase
        r.status = sts;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lppd_result_t want;
        if (!rst_n)
        begin
            ph = PH_IDLE;
            sts = ST_OK;
            pos = '0;
            decl_len = '0;
            max_len = MAX_LEN_DEFAULT;
            cur_mark = '0;
            cur_head = '0;
            predicted_results.delete();
            result_index = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                max_len = cfg_wdata;
            if (s_tvalid && s_tready)
                predicted_results.push_back(deframe_byte(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("result item with nothing expected");
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("out_byte", 16'(m_tdata[7:0]), 16'(want.out_byte));
                    check_field("frame_start", 16'(m_tuser[0]), 16'(want.frame_start));
                    check_field("frame_end", 16'(m_tlast), 16'(want.frame_end));
                    check_field("marker_code", 16'(m_tdata[15:8]),
                                16'(want.marker_code));
                    check_field("frame_length", m_tdata[31:16], want.frame_length);
                    check_field("head_code", 16'(m_tdata[39:32]), 16'(want.head_code));
                    check_field("head_code_valid", 16'(m_tuser[1]),
                                16'(want.head_code_valid));
                    check_field("status", 16'(m_tuser[3:2]), 16'(want.status));
                end
                result_index++;
            end
            pending = predicted_results.size();
        end
    end

endmodule

// File: test/tb_length_prefixed_packet_deframer.sv
// Testbench top for the packet deframer: stimulus, flow control and verdict.
module tb_length_prefixed_packet_deframer;
    import lppd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [7:0] out_byte, [15:8] marker_code,
                                 // [31:16] frame_length, [39:32] head_code
    logic        m_tlast;        // frame_end
    logic [3:0]  m_tuser;        // [0] frame_start, [1] head_code_valid, [3:2] status

    int          mismatches;
    int          pending;

    // Percent of cycles in which each side holds off
    int          send_idle_pct = 10;
    int          recv_idle_pct = 76;

    // Mirror of the programmed max_frame_length, used to shape packet lengths
    int          max_len_now = int'(MAX_LEN_DEFAULT);

    length_prefixed_packet_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    deframer_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Receiver back-pressure: drop tready at random, redrawn every cycle.
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Offer one item and hold it until the handshake edge. Called at a rising
    // edge; tvalid stays high on return so back-to-back items never toggle it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Send a complete well-formed packet with random head code and body.
    task automatic send_packet(input logic [7:0] mark, input int len);
        logic long_fmt;
        int   body_len;
        long_fmt = (mark == MARK_LONG_A || mark == MARK_LONG_B);
        body_len = len - (long_fmt ? 4 : 3);
        send_byte(mark);
        if (long_fmt)
            send_byte(8'(len >> 8));
        send_byte(8'(len));
        send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < body_len; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Drop tvalid and hold until every predicted result has been taken.
    // Sample on the falling edge so the checker's count is settled.
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Program max_frame_length; only called with the block idle.
    task automatic write_max_len(input int value);
        cfg_we <= 1'b1;
        cfg_wdata <= 16'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        max_len_now = value;
    endtask

    initial
    begin
        int          seg;
        int          seg_bytes;
        int          roll;
        int          cap;
        int          hdr;
        int          len;
        int          kind;
        logic [7:0]  mark;
        logic [7:0]  b;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets at the reset limit of 8192: each marker, header-size
        // packets where the head code byte also ends the packet, and the byte
        // extremes in head and body.
        send_byte(MARK_SHORT_A); send_byte(8'h03); send_byte(8'h00);
        send_byte(MARK_SHORT_B); send_byte(8'h04); send_byte(8'hFF); send_byte(8'h80);
        send_byte(MARK_LONG_A); send_byte(8'h00); send_byte(8'h04); send_byte(8'h7F);
        send_byte(MARK_LONG_B); send_byte(8'h00); send_byte(8'h06);
        send_byte(8'h01); send_byte(8'h00); send_byte(8'hFF);
        send_byte(MARK_SHORT_A); send_byte(8'h05);
        send_byte(8'hAA); send_byte(8'h55); send_byte(8'hFE);

        // Random packets in six segments, each under its own length limit.
        // Idling: sender light and receiver heavy, then swapped, then none.
        for (seg = 0; seg < 6; seg++)
        begin
            drain();
            case (seg)
                0: write_max_len(65535);
                1: write_max_len(4);
                2: write_max_len(300);
                3: write_max_len(int'(MAX_LEN_DEFAULT));
                4: write_max_len($urandom_range(5, 65534));
                default: write_max_len(255);
            endcase
            if (seg < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 76;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            seg_bytes = 0;
            while (seg_bytes < 140)
            begin
                case ($urandom_range(0, 3))
                    0: mark = MARK_SHORT_A;
                    1: mark = MARK_SHORT_B;
                    2: mark = MARK_LONG_A;
                    default: mark = MARK_LONG_B;
                endcase
                hdr = (mark == MARK_LONG_A || mark == MARK_LONG_B) ? 4 : 3;
                // Keep lengths short; hit the limit itself now and then.
                cap = max_len_now;
                if (hdr == 3 && cap > 255)
                    cap = 255;
                if (cap > 300)
                    cap = 300;
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    len = cap;
                else if (roll < 20)
                    len = $urandom_range(hdr, cap);
                else
                    len = $urandom_range(hdr, (cap < 20) ? cap : 20);
                send_packet(mark, len);
                seg_bytes += len;
            end
        end

        // The error latches until reset, so end the run with one broken
        // header: an unknown marker, a length below the header size, or a
        // length above the limit. Then stream bytes through the latched block.
        drain();
        write_max_len($urandom_range(4, 2000));
        kind = $urandom_range(0, 2);
        if (kind == 0)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == MARK_SHORT_A || b == MARK_SHORT_B ||
                   b == MARK_LONG_A || b == MARK_LONG_B);
            send_byte(b);
        end
        else if (kind == 1)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_byte($urandom_range(0, 1) ? MARK_SHORT_A : MARK_SHORT_B);
                send_byte(8'($urandom_range(0, 2)));
            end
            else
            begin
                send_byte($urandom_range(0, 1) ? MARK_LONG_A : MARK_LONG_B);
                send_byte(8'h00);
                send_byte(8'($urandom_range(0, 3)));
            end
        end
        else
        begin
            len = ($urandom_range(0, 1) == 0) ? max_len_now + 1
                                                : $urandom_range(max_len_now + 1, 65535);
            send_byte($urandom_range(0, 1) ? MARK_LONG_A : MARK_LONG_B);
            send_byte(8'(len >> 8));
            send_byte(8'(len));
        end
        for (int i = 0; i < 30; i++)
            send_byte(8'($urandom_range(0, 255)));

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
